[hw/rtl/fbpa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared sizes, codes and types of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // pool and wait queue capacity
    localparam int MAX_BLOCKS  = 64;
    localparam int MAX_WAITERS = 16;

    // field widths
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int REQ_W    = 8;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int CIDX_W   = 2;

    // free stack: entry index and fill count
    localparam int FS_AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int FT_W  = $clog2(MAX_BLOCKS + 1);
    // wait queue: entry index and fill count
    localparam int WQ_AW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int WQ_CW = $clog2(MAX_WAITERS + 1);
    // pool span in bytes, count times size
    localparam int LIM_W = COUNT_W + SIZE_W;

    // operation codes
    localparam logic [OP_W-1:0] OP_TAKE_WAIT = 2'd0;
    localparam logic [OP_W-1:0] OP_TAKE_POLL = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOBLOCK = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BADADDR = 3'd2;
    localparam logic [STATUS_W-1:0] ST_QUEUED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QFULL   = 3'd4;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_POOL_BASE   = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

    // remainder unit response
    typedef struct packed {
        logic done;
        logic rem_zero;
    } t_mod_rsp;

endpackage

[hw/rtl/fbpa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [AW-1:0]            i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [AW-1:0]            i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/fbpa_mod.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_mod
// Bit-serial remainder unit: one restoring step per cycle over the
// dividend, reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module fbpa_mod
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ADDR_W-1:0] i_dividend,
    input  logic [SIZE_W-1:0] i_divisor,
    output t_mod_rsp          o_rsp
);
    localparam int CNT_W = $clog2(ADDR_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_shift;
    logic [SIZE_W-1:0] r_rem;
    logic [SIZE_W-1:0] r_div;
    logic [SIZE_W:0]   w_trial;
    logic [SIZE_W:0]   w_diff;

    // one restoring step
    assign w_trial = {r_rem, r_shift[ADDR_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    // sequencing control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ADDR_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
            r_div   <= i_divisor;
        end else if (r_busy) begin
            r_shift <= {r_shift[ADDR_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_div}) begin
                r_rem <= w_diff[SIZE_W-1:0];
            end else begin
                r_rem <= w_trial[SIZE_W-1:0];
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

[hw/rtl/fixed_block_pool_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_top
// Fixed-size block pool with a LIFO free stack, bump allocation of unused
// blocks and a FIFO of waiting requesters.
// ----------------------------------------------------------------------------
// One request word is handled at a time and gives at most one result word.
// A take passes the execute and done states, and the read wait state too
// when it pops the free stack, whose RAM read is registered. A release
// waits in the check state for the bit-serial remainder unit that checks
// block alignment one address bit per cycle (32 steps), then on a handoff
// reads the wait queue in the read wait state. The output register lets a
// new request word in while the last result word waits to be taken. Op
// code 3 is dropped with no result. Configuration writes are taken every
// cycle and must only happen while the block is idle.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator_top
    import fbpa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [ADDR_W-1:0] i_cfg_data,
    // request stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [39:0]       s_axis_tdata,   // requester[7:0], block_addr[39:8]
    input  logic [OP_W-1:0]   s_axis_tuser,   // op[1:0]
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [39:0]       m_axis_tdata,   // result_addr[31:0], handoff_requester[39:32]
    output logic [3:0]        m_axis_tuser    // status[2:0], handoff_valid[3]
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_MOD    = 5'b00100,
        S_RDWAIT = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state             r_state, n_state;

    // configuration
    logic [ADDR_W-1:0]  r_cfg_base;
    logic [SIZE_W-1:0]  r_cfg_size;
    logic [COUNT_W-1:0] r_cfg_count;

    // captured request
    logic [OP_W-1:0]    r_op;
    logic [REQ_W-1:0]   r_req;
    logic [ADDR_W-1:0]  r_addr;

    // pool state
    logic [FT_W-1:0]    r_free_top, n_free_top;
    logic [FT_W-1:0]    r_next_unused, n_next_unused;
    logic [WQ_AW-1:0]   r_wq_head, n_wq_head;
    logic [WQ_CW-1:0]   r_wq_count, n_wq_count;
    logic               r_in_range, n_in_range;

    // pending result
    logic [STATUS_W-1:0] r_res_status, n_res_status;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_res_hv, n_res_hv;
    logic [REQ_W-1:0]    r_res_hreq, n_res_hreq;

    // output register
    logic                r_m_valid, n_m_valid;
    logic [STATUS_W-1:0] r_m_status;
    logic [ADDR_W-1:0]   r_m_addr;
    logic                r_m_hv;
    logic [REQ_W-1:0]    r_m_hreq;
    logic                w_m_load;

    // memory ports
    logic               w_fs_we;
    logic [FS_AW-1:0]   w_fs_waddr;
    logic [FS_AW-1:0]   w_fs_raddr;
    logic [ADDR_W-1:0]  w_fs_rdata;
    logic               w_wq_we;
    logic [WQ_AW-1:0]   w_wq_waddr;
    logic [REQ_W-1:0]   w_wq_rdata;

    // remainder unit
    logic               w_mod_start;
    logic [ADDR_W-1:0]  w_offset;
    t_mod_rsp           w_mod_rsp;

    // derived values
    logic [FT_W-1:0]            w_ft_dec;
    logic [WQ_CW:0]             w_tail_sum;
    logic [WQ_CW:0]             w_tail_full;
    logic [FT_W+SIZE_W-1:0]     w_bump_prod;
    logic [ADDR_W-1:0]          w_bump_addr;
    logic                       w_bump_ok;
    logic [LIM_W-1:0]           w_span;
    logic                       w_release_ok;
    logic                       w_in_acc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_size  <= SIZE_W'(16);
            r_cfg_count <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_POOL_BASE:   r_cfg_base  <= i_cfg_data;
                CFG_BLOCK_SIZE:  r_cfg_size  <= i_cfg_data[SIZE_W-1:0];
                CFG_BLOCK_COUNT: r_cfg_count <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op   <= s_axis_tuser;
            r_req  <= s_axis_tdata[REQ_W-1:0];
            r_addr <= s_axis_tdata[REQ_W+ADDR_W-1:REQ_W];
        end
    end

    // free stack pop address, wait queue tail
    assign w_ft_dec    = r_free_top - FT_W'(1);
    assign w_fs_raddr  = w_ft_dec[FS_AW-1:0];
    assign w_fs_waddr  = r_free_top[FS_AW-1:0];
    assign w_tail_sum  = (WQ_CW+1)'(r_wq_head) + (WQ_CW+1)'(r_wq_count);
    assign w_tail_full = (w_tail_sum >= (WQ_CW+1)'(MAX_WAITERS))
                         ? w_tail_sum - (WQ_CW+1)'(MAX_WAITERS) : w_tail_sum;
    assign w_wq_waddr  = w_tail_full[WQ_AW-1:0];

    // bump allocation address and limit
    assign w_bump_prod = {{SIZE_W{1'b0}}, r_next_unused} * {{FT_W{1'b0}}, r_cfg_size};
    assign w_bump_addr = r_cfg_base + ADDR_W'(w_bump_prod);
    assign w_bump_ok   = ({{COUNT_W{1'b0}}, r_next_unused} < {{FT_W{1'b0}}, r_cfg_count})
                         && (r_next_unused < FT_W'(MAX_BLOCKS));

    // release range check
    assign w_span       = {{SIZE_W{1'b0}}, r_cfg_count} * {{COUNT_W{1'b0}}, r_cfg_size};
    assign w_offset     = r_addr - r_cfg_base;
    assign w_release_ok = r_in_range && (r_cfg_size != '0) && w_mod_rsp.rem_zero;

    // sequencer
    always_comb begin
        n_state       = r_state;
        n_free_top    = r_free_top;
        n_next_unused = r_next_unused;
        n_wq_head     = r_wq_head;
        n_wq_count    = r_wq_count;
        n_in_range    = r_in_range;
        n_res_status  = r_res_status;
        n_res_addr    = r_res_addr;
        n_res_hv      = r_res_hv;
        n_res_hreq    = r_res_hreq;
        w_fs_we       = 1'b0;
        w_wq_we       = 1'b0;
        w_mod_start   = 1'b0;
        w_m_load      = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = ST_OK;
                n_res_addr   = '0;
                n_res_hv     = 1'b0;
                n_res_hreq   = '0;
                n_state      = S_DONE;
                case (r_op)
                    OP_TAKE_WAIT, OP_TAKE_POLL: begin
                        if (r_free_top != '0) begin
                            // pop: the read at free_top - 1 lands next cycle
                            n_free_top = w_ft_dec;
                            n_state    = S_RDWAIT;
                        end else if (w_bump_ok) begin
                            n_res_addr    = w_bump_addr;
                            n_next_unused = r_next_unused + FT_W'(1);
                        end else if (r_op == OP_TAKE_POLL) begin
                            n_res_status = ST_NOBLOCK;
                        end else if (r_wq_count < WQ_CW'(MAX_WAITERS)) begin
                            w_wq_we      = 1'b1;
                            n_wq_count   = r_wq_count + WQ_CW'(1);
                            n_res_status = ST_QUEUED;
                        end else begin
                            n_res_status = ST_QFULL;
                        end
                    end
                    OP_RELEASE: begin
                        n_in_range  = (r_addr >= r_cfg_base)
                                      && (w_offset < ADDR_W'(w_span));
                        w_mod_start = 1'b1;
                        n_state     = S_MOD;
                    end
                    default: begin
                        // unused op: no result
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_MOD: begin
                if (w_mod_rsp.done) begin
                    n_state = S_DONE;
                    if (!w_release_ok) begin
                        n_res_status = ST_BADADDR;
                    end else if (r_wq_count != '0) begin
                        // handoff: the read at head lands next cycle
                        n_res_hv   = 1'b1;
                        n_res_addr = r_addr;
                        n_wq_count = r_wq_count - WQ_CW'(1);
                        n_wq_head  = (r_wq_head == WQ_AW'(MAX_WAITERS - 1))
                                     ? '0 : r_wq_head + WQ_AW'(1);
                        n_state    = S_RDWAIT;
                    end else if (r_free_top < FT_W'(MAX_BLOCKS)) begin
                        w_fs_we    = 1'b1;
                        n_free_top = r_free_top + FT_W'(1);
                    end
                end
            end
            S_RDWAIT: begin
                if (r_res_hv) begin
                    n_res_hreq = w_wq_rdata;
                end else begin
                    n_res_addr = w_fs_rdata;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    w_m_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid
    always_comb begin
        n_m_valid = r_m_valid && !m_axis_tready;
        if (w_m_load) begin
            n_m_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_free_top    <= '0;
            r_next_unused <= '0;
            r_wq_head     <= '0;
            r_wq_count    <= '0;
            r_m_valid     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_free_top    <= n_free_top;
            r_next_unused <= n_next_unused;
            r_wq_head     <= n_wq_head;
            r_wq_count    <= n_wq_count;
            r_m_valid     <= n_m_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_in_range   <= n_in_range;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_hv     <= n_res_hv;
        r_res_hreq   <= n_res_hreq;
        if (w_m_load) begin
            r_m_status <= r_res_status;
            r_m_addr   <= r_res_addr;
            r_m_hv     <= r_res_hv;
            r_m_hreq   <= r_res_hreq;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_hreq, r_m_addr};
    assign m_axis_tuser  = {r_m_hv, r_m_status};

    // free stack of released block addresses
    fbpa_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (MAX_BLOCKS)
    ) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (w_fs_we),
        .i_waddr (w_fs_waddr),
        .i_wdata (r_addr),
        .i_raddr (w_fs_raddr),
        .o_rdata (w_fs_rdata)
    );

    // queue of waiting requesters
    fbpa_ram #(
        .WIDTH (REQ_W),
        .DEPTH (MAX_WAITERS)
    ) u_wait_queue (
        .i_clk   (i_clk),
        .i_we    (w_wq_we),
        .i_waddr (w_wq_waddr),
        .i_wdata (r_req),
        .i_raddr (r_wq_head),
        .o_rdata (w_wq_rdata)
    );

    // alignment check
    fbpa_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (w_offset),
        .i_divisor  (r_cfg_size),
        .o_rsp      (w_mod_rsp)
    );

    // free stack and wait queue never overfill
    a_free_top_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_top <= FT_W'(MAX_BLOCKS))
        else $error("free stack overfilled");

    a_wq_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wq_count <= WQ_CW'(MAX_WAITERS))
        else $error("wait queue overfilled");

    // remainder result only arrives while the release waits for it
    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_rsp.done |-> (r_state == S_MOD))
        else $error("remainder result outside release check");

    // a handoff always reports ok
    a_handoff_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_hv) |-> (r_m_status == ST_OK))
        else $error("handoff with error status");

    // a queued take never leaves a block available
    a_queue_only_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wq_we |=> (r_free_top == '0))
        else $error("requester queued while free stack holds blocks");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the fixed block pool allocator: a directed table
// of pool setups and request words, then random phases over many pool
// setups, with random gaps and back-pressure, checked against an in-bench
// model of the free stack, the bump index and the wait queue.
// ----------------------------------------------------------------------------
module tb;
    import fbpa_pkg::*;

    // unused op code, dropped by the block with no result
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES  = 48;
    localparam int QUIET_LIMIT    = 2000;
    localparam int PHASES         = 10;
    localparam int WORDS_PER_PHASE = 125;
    localparam int MAX_REPORTS    = 40;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic                handoff;
        logic [REQ_W-1:0]    taker;
    } t_alloc_reply;

    typedef struct {
        bit                 is_cfg;
        logic [CIDX_W-1:0]  cidx;
        logic [ADDR_W-1:0]  cdata;
        logic [OP_W-1:0]    op;
        logic [REQ_W-1:0]   req;
        logic [ADDR_W-1:0]  addr;
        bit                 typed;
        t_alloc_reply       want;
    } t_table_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0] i_cfg_data;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [39:0]       s_axis_tdata;   // requester[7:0], block_addr[39:8]
    logic [OP_W-1:0]   s_axis_tuser;   // op[1:0]
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [39:0]       m_axis_tdata;   // result_addr[31:0], handoff_requester[39:32]
    logic [3:0]        m_axis_tuser;   // status[2:0], handoff_valid[3]

    fixed_block_pool_allocator_top dut (.*);

    // pool setup as the block should hold it
    logic [ADDR_W-1:0]  pool_base;
    logic [SIZE_W-1:0]  block_size;
    logic [COUNT_W-1:0] block_count;

    // free stack, bump index and waiter fifo
    logic [ADDR_W-1:0] free_blocks [MAX_BLOCKS];
    int                free_top;
    int                next_unused;
    logic [REQ_W-1:0]  waiters [MAX_WAITERS];
    int                waiter_head;
    int                waiter_count;

    t_alloc_reply awaited_replies[$];
    t_table_row   directed_rows[$];

    bit steady;
    int fail_count;
    int words_sent;
    int replies_seen;
    int handoffs;
    int queue_full_hits;
    int stack_drops;
    int cfg_writes;
    int quiet_cycles;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // expected reply of one request word; also advances the pool state
    task automatic pool_respond(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                                input logic [ADDR_W-1:0] addr, output bit has_reply,
                                output t_alloc_reply r);
        logic [63:0] span;
        logic [63:0] limit;
        logic [63:0] offset;
        bit          got;
        bit          in_pool;
        r         = '0;
        r.status  = ST_OK;
        has_reply = (op != OP_UNUSED);
        got       = 1'b0;
        if (op == OP_TAKE_WAIT || op == OP_TAKE_POLL) begin
            // most recently freed block first, then the next unused one
            if (free_top > 0) begin
                free_top--;
                r.addr = free_blocks[free_top];
                got    = 1'b1;
            end else if (next_unused < block_count && next_unused < MAX_BLOCKS) begin
                span   = 64'(pool_base) + 64'(next_unused) * 64'(block_size);
                r.addr = span[ADDR_W-1:0];
                next_unused++;
                got    = 1'b1;
            end
            if (!got) begin
                if (op == OP_TAKE_POLL) begin
                    r.status = ST_NOBLOCK;
                end else if (waiter_count < MAX_WAITERS) begin
                    waiters[(waiter_head + waiter_count) % MAX_WAITERS] = req;
                    waiter_count++;
                    r.status = ST_QUEUED;
                end else begin
                    r.status = ST_QFULL;
                    queue_full_hits++;
                end
            end
        end else if (op == OP_RELEASE) begin
            // range against the unwrapped limit, then block alignment
            limit   = 64'(pool_base) + 64'(block_count) * 64'(block_size);
            offset  = 64'(addr) - 64'(pool_base);
            in_pool = (block_size != 0) && (64'(addr) >= 64'(pool_base)) &&
                      (64'(addr) < limit) && (offset % 64'(block_size) == 0);
            if (!in_pool) begin
                r.status = ST_BADADDR;
            end else if (waiter_count > 0) begin
                r.taker     = waiters[waiter_head];
                r.handoff   = 1'b1;
                r.addr      = addr;
                waiter_head = (waiter_head + 1) % MAX_WAITERS;
                waiter_count--;
                handoffs++;
            end else if (free_top < MAX_BLOCKS) begin
                free_blocks[free_top] = addr;
                free_top++;
            end else begin
                stack_drops++;
            end
        end
    endtask

    // one request word, with a random gap ahead of it
    task automatic send_word(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                             input logic [ADDR_W-1:0] addr, input bit typed,
                             input t_alloc_reply want);
        int           gap;
        bit           has_reply;
        t_alloc_reply r;
        gap = steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {addr, req};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        pool_respond(op, req, addr, has_reply, r);
        if (has_reply) awaited_replies.push_back(typed ? want : r);
    endtask

    // register write once the block has gone idle
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        case (idx)
            CFG_POOL_BASE:   pool_base   = data;
            CFG_BLOCK_SIZE:  block_size  = data[SIZE_W-1:0];
            CFG_BLOCK_COUNT: block_count = data[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    // release address: mostly real blocks, some near misses and noise
    function automatic logic [ADDR_W-1:0] pick_release_addr();
        logic [63:0] span;
        int          k;
        int          sel;
        sel  = $urandom_range(0, 9);
        k    = (block_count == 0) ? 0 : $urandom_range(0, block_count - 1);
        span = 64'(pool_base) + 64'(k) * 64'(block_size);
        if (sel <= 6) return span[ADDR_W-1:0];
        if (sel == 7) return span[ADDR_W-1:0] + ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
        if (sel == 8) begin
            span = 64'(pool_base) + 64'(block_count) * 64'(block_size);
            return span[ADDR_W-1:0];
        end
        return $urandom;
    endfunction

    function automatic void add_cfg(input logic [CIDX_W-1:0] idx, input logic [ADDR_W-1:0] d);
        t_table_row row;
        row        = '{default: '0};
        row.is_cfg = 1'b1;
        row.cidx   = idx;
        row.cdata  = d;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_word(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                                     input logic [ADDR_W-1:0] addr);
        t_table_row row;
        row      = '{default: '0};
        row.op   = op;
        row.req  = req;
        row.addr = addr;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed(input logic [OP_W-1:0] op, input logic [REQ_W-1:0] req,
                                      input logic [ADDR_W-1:0] addr,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [ADDR_W-1:0] raddr, input logic hv,
                                      input logic [REQ_W-1:0] taker);
        t_table_row row;
        row       = '{default: '0};
        row.op    = op;
        row.req   = req;
        row.addr  = addr;
        row.typed = 1'b1;
        row.want  = '{status: st, addr: raddr, handoff: hv, taker: taker};
        directed_rows.push_back(row);
    endfunction

    // result side: random hold-off once a word is waiting, then compare
    initial begin
        t_alloc_reply seen;
        t_alloc_reply want;
        int           stall;
        m_axis_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 8);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                do @(posedge i_clk); while (!m_axis_tvalid);
                repeat (stall - 1) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
            replies_seen++;
            seen = '{status: m_axis_tuser[2:0], addr: m_axis_tdata[31:0],
                     handoff: m_axis_tuser[3], taker: m_axis_tdata[39:32]};
            if (awaited_replies.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected word status=%0d addr=%h handoff=%b taker=%h",
                             $time, seen.status, seen.addr, seen.handoff, seen.taker);
            end else begin
                want = awaited_replies.pop_front();
                if (seen !== want) begin
                    fail_count++;
                    // fields as status/addr/handoff/taker
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch expected %0d/%h/%b/%h actual %0d/%h/%b/%h",
                                 $time, want.status, want.addr, want.handoff, want.taker,
                                 seen.status, seen.addr, seen.handoff, seen.taker);
                end
            end
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus
    initial begin
        int          ph;
        int          n;
        int          pick;
        int          mode;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] base_v;
        logic [ADDR_W-1:0] size_v;
        logic [ADDR_W-1:0] count_v;
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        quiet_cycles  = 0;
        fail_count    = 0;
        steady        = 1'b0;
        pool_base     = '0;
        block_size    = SIZE_W'(16);
        block_count   = '0;
        free_top      = 0;
        next_unused   = 0;
        waiter_head   = 0;
        waiter_count  = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty pool after reset: no block, queued, bad address, dropped op
        add_typed(OP_TAKE_POLL, 8'h00, 32'h0000_0000, ST_NOBLOCK, '0, 1'b0, '0);
        add_typed(OP_TAKE_WAIT, 8'hFF, 32'hFFFF_FFFF, ST_QUEUED, '0, 1'b0, '0);
        add_typed(OP_RELEASE, 8'h00, 32'h0000_0000, ST_BADADDR, '0, 1'b0, '0);
        add_word(OP_UNUSED, 8'hAA, 32'h5555_5555);
        // four blocks at the top of the address space, the last two wrap
        add_cfg(CFG_POOL_BASE, 32'hFFFF_FF00);
        add_cfg(CFG_BLOCK_SIZE, 32'h0000_0080);
        add_cfg(CFG_BLOCK_COUNT, 32'd4);
        add_word(OP_TAKE_POLL, 8'h11, 32'h0);
        add_typed(OP_RELEASE, 8'h22, 32'hFFFF_FF80, ST_OK, 32'hFFFF_FF80, 1'b1, 8'hFF);
        add_typed(OP_RELEASE, 8'h00, 32'hFFFF_FF81, ST_BADADDR, '0, 1'b0, '0);
        add_typed(OP_RELEASE, 8'h00, 32'h0000_0000, ST_BADADDR, '0, 1'b0, '0);
        add_word(OP_TAKE_WAIT, 8'h01, 32'h0);
        add_word(OP_TAKE_WAIT, 8'h02, 32'h0);
        add_word(OP_TAKE_WAIT, 8'h03, 32'h0);
        add_word(OP_TAKE_WAIT, 8'h04, 32'h0);
        add_word(OP_TAKE_POLL, 8'h05, 32'h0);
        add_word(OP_RELEASE, 8'h06, 32'hFFFF_FF00);
        add_word(OP_RELEASE, 8'h07, 32'hFFFF_FF00);
        add_word(OP_TAKE_POLL, 8'h08, 32'h0);
        // zero block size: bumps all give the base, releases all rejected
        add_cfg(CFG_POOL_BASE, 32'h0000_1000);
        add_cfg(CFG_BLOCK_SIZE, 32'h0);
        add_cfg(CFG_BLOCK_COUNT, 32'd64);
        add_typed(OP_TAKE_POLL, 8'h09, 32'h0, ST_OK, 32'h0000_1000, 1'b0, '0);
        add_typed(OP_RELEASE, 8'h0A, 32'h0000_1000, ST_BADADDR, '0, 1'b0, '0);
        // largest base and block size
        add_cfg(CFG_POOL_BASE, 32'hFFFF_FFFF);
        add_cfg(CFG_BLOCK_SIZE, 32'h0000_FFFF);
        add_word(OP_TAKE_WAIT, 8'h80, 32'h0);
        add_word(OP_RELEASE, 8'h7F, 32'hFFFF_FFFF);
        add_word(OP_RELEASE, 8'h7F, 32'h0000_FFFE);
        add_word(OP_TAKE_POLL, 8'h01, 32'h0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_cfg)
                write_reg(directed_rows[i].cidx, directed_rows[i].cdata);
            else
                send_word(directed_rows[i].op, directed_rows[i].req, directed_rows[i].addr,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each with its own pool setup and op mix
        for (ph = 0; ph < PHASES; ph++) begin
            mode = ph % 3;
            if (ph == 0) begin
                base_v  = 32'h0;
                size_v  = 32'd1;
                count_v = 32'd64;
            end else if (ph == 1) begin
                base_v  = 32'hFFFF_FFFF;
                size_v  = 32'hFFFF;
                count_v = 32'd64;
            end else begin
                case ($urandom_range(0, 3))
                    0: base_v = 32'h0;
                    1: base_v = 32'hFFFF_FFFF;
                    2: base_v = $urandom & 32'hFFFF_F000;
                    default: base_v = $urandom;
                endcase
                case ($urandom_range(0, 4))
                    0: size_v = 32'd1;
                    1: size_v = 32'hFFFF;
                    2: size_v = $urandom_range(1, 64);
                    3: size_v = 32'd1 << $urandom_range(0, 15);
                    default: size_v = $urandom_range(1, 65535);
                endcase
                if (mode == 0 && $urandom_range(0, 3) == 0)
                    count_v = 32'd0;
                else
                    count_v = $urandom_range(1, 64);
            end
            write_reg(CFG_POOL_BASE, base_v);
            write_reg(CFG_BLOCK_SIZE, size_v);
            write_reg(CFG_BLOCK_COUNT, count_v);
            steady = (ph % 4 == 3);
            n = 0;
            while (n < WORDS_PER_PHASE) begin
                // balanced, take-heavy, or release-heavy mix
                pick = $urandom_range(0, 99);
                case (mode)
                    0: op = (pick < 30) ? OP_TAKE_WAIT : (pick < 55) ? OP_TAKE_POLL :
                            (pick < 97) ? OP_RELEASE : OP_UNUSED;
                    1: op = (pick < 55) ? OP_TAKE_WAIT : (pick < 70) ? OP_TAKE_POLL :
                            (pick < 98) ? OP_RELEASE : OP_UNUSED;
                    default: op = (pick < 12) ? OP_TAKE_WAIT : (pick < 18) ? OP_TAKE_POLL :
                                  (pick < 97) ? OP_RELEASE : OP_UNUSED;
                endcase
                send_word(op, 8'($urandom_range(0, 255)),
                          (op == OP_RELEASE) ? pick_release_addr() : $urandom, 1'b0, '0);
                if (op != OP_UNUSED) n++;
            end
        end
        steady = 1'b0;

        // drain
        s_axis_tvalid <= 1'b0;
        while (awaited_replies.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d request words and %0d result words over %0d register writes",
                 words_sent, replies_seen, cfg_writes);
        $display("handoffs %0d, wait queue full %0d, free stack drops %0d",
                 handoffs, queue_full_hits, stack_drops);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
